FILE: src/lnqd_pkg.sv
package lnqd_pkg;

  // Default ring size in nibble entries (one slot is kept free)
  localparam int unsigned QueueDepthDef = 64;

  // Command codes on the request port
  localparam logic [1:0] CMD_PUSH_DATA  = 2'd0;
  localparam logic [1:0] CMD_PUSH_INSTR = 2'd1;
  localparam logic [1:0] CMD_TICK       = 2'd2;

  // Nibble masks
  localparam logic [7:0] NibbleMask = 8'h0F;
  localparam logic [7:0] HighBit    = 8'h80;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_INSTR,
    KIND_TICK,
    KIND_NONE
  } kind_e;

  // Classified request handed from front to back
  typedef struct packed {
    kind_e      kind;
    logic [7:0] value;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic [3:0] nibble;
    logic       rs;
    logic       en;
    logic       dropped;
    logic       empty;
  } res_t;

  // Handshake between a producer and a consumer stage
  typedef struct packed {
    logic vld;
    logic rdy;
  } hs_t;

endpackage

FILE: src/lnqd_ram.sv
module lnqd_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Single write port, registered read (old data on collision)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/lnqd_fifo.sv
module lnqd_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  // Two-entry register queue: sustains one request per cycle while not full
  logic [WIDTH-1:0] slot_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

FILE: src/lnqd_front.sv
module lnqd_front import lnqd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command_i,
  input  logic [7:0] byte_value_i,
  output hs_t        cmd_hs_o,
  input  logic       cmd_take_i,
  output cmd_t       cmd_o
);

  cmd_t dec;
  logic cq_empty;

  // Classify the request
  always_comb begin
    dec.value = byte_value_i;
    case (command_i)
      CMD_PUSH_DATA:  dec.kind = KIND_DATA;
      CMD_PUSH_INSTR: dec.kind = KIND_INSTR;
      CMD_TICK:       dec.kind = KIND_TICK;
      default:        dec.kind = KIND_NONE;
    endcase
  end

  // Decoupling queue towards the back end
  lnqd_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (dec),
    .full_o  (full),
    .pop_i   (cmd_take_i),
    .rdata_o (cmd_o),
    .empty_o (cq_empty)
  );

  assign cmd_hs_o.vld = !cq_empty;
  assign cmd_hs_o.rdy = cmd_take_i;

endmodule

FILE: src/lnqd_back.sv
module lnqd_back import lnqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_vld_i,
  input  cmd_t cmd_i,
  output logic cmd_take_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  // Nibble count holds 0..QUEUE_DEPTH-1; bytes are stored whole
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned BDepth = (QUEUE_DEPTH + 1) / 2;
  localparam int unsigned BaW    = $clog2(BDepth);

  logic [CntW-1:0] used_q, used_d;
  logic [BaW-1:0]  wr_q, wr_d;
  logic [BaW-1:0]  rd_q, rd_d;
  logic            half_q, half_d;   // high nibble of head already sent
  logic            phase_q, phase_d; // E level
  logic [3:0]      nib_q, nib_d;
  logic            rs_q, rs_d;
  logic            byp_q;
  logic [8:0]      byp_data_q;
  logic            we;
  logic [8:0]      wdata;
  logic [8:0]      rdata;
  logic [8:0]      head;
  logic            fire;
  logic            dropped;

  assign fire       = cmd_vld_i && !res_full_i;
  assign cmd_take_o = fire;
  assign res_push_o = fire;
  assign head       = byp_q ? byp_data_q : rdata;
  assign wdata      = {cmd_i.kind == KIND_INSTR, cmd_i.value};

  // Execute one request
  always_comb begin
    used_d  = used_q;
    wr_d    = wr_q;
    rd_d    = rd_q;
    half_d  = half_q;
    phase_d = phase_q;
    nib_d   = nib_q;
    rs_d    = rs_q;
    we      = 1'b0;
    dropped = 1'b0;
    if (fire) begin
      case (cmd_i.kind)
        KIND_DATA, KIND_INSTR: begin
          if (used_q < CntW'(QUEUE_DEPTH - 2)) begin
            we     = 1'b1;
            wr_d   = (wr_q == BaW'(BDepth - 1)) ? '0 : wr_q + BaW'(1);
            used_d = used_q + CntW'(2);
          end else begin
            dropped = 1'b1;
          end
        end
        KIND_TICK: begin
          if (phase_q) begin
            phase_d = 1'b0;
          end else if (used_q != '0) begin
            nib_d   = half_q ? 4'(head[7:0] & NibbleMask) : head[7:4];
            rs_d    = !head[8];
            phase_d = 1'b1;
            used_d  = used_q - CntW'(1);
            half_d  = !half_q;
            if (half_q) begin
              rd_d = (rd_q == BaW'(BDepth - 1)) ? '0 : rd_q + BaW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    res_o.nibble  = nib_d;
    res_o.rs      = rs_d;
    res_o.en      = phase_d;
    res_o.dropped = dropped;
    res_o.empty   = (used_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
      half_q  <= 1'b0;
      phase_q <= 1'b0;
      nib_q   <= 4'd0;
      rs_q    <= 1'b0;
      byp_q   <= 1'b0;
    end else begin
      used_q  <= used_d;
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      half_q  <= half_d;
      phase_q <= phase_d;
      nib_q   <= nib_d;
      rs_q    <= rs_d;
      byp_q   <= we && (wr_q == rd_d);
    end
  end

  // Forward a byte written to the slot being read this cycle
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  // Byte store, head slot re-read every cycle
  lnqd_ram #(
    .WIDTH (9),
    .DEPTH (BDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_q),
    .wdata_i (wdata),
    .raddr_i (rd_d),
    .rdata_o (rdata)
  );

endmodule

FILE: src/lcd_nibble_queue_driver_top.sv
// Character LCD driver for a 4-bit bus. Each request is a data push, an
// instruction push or a driver tick; every request yields exactly one result
// carrying the pin levels (D7..D4, RS, E), a drop flag and the queue status.
// A push queues the byte as two nibbles, high first, and is refused when
// fewer than two of the QUEUE_DEPTH-1 nibble slots are free. A tick raises E
// with the next nibble, or drops E if it is high. One request is taken per
// cycle while the result queue has room; the request is first held in the
// front-end command queue, then the back end executes it and writes its
// result into the result queue, from which it is popped at the result ports.
// The nibble store is a RAM of (QUEUE_DEPTH+1)/2 byte entries with a
// registered read of the head slot.
module lcd_nibble_queue_driver_top import lnqd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [1:0] command_i,
  input  logic [7:0] byte_value_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] bus_nibble_o,
  output logic       register_select_o,
  output logic       enable_pin_o,
  output logic       push_dropped_o,
  output logic       queue_empty_o
);

  hs_t  cmd_hs;
  cmd_t cmd;
  logic cmd_take;
  logic res_full;
  logic res_push;
  res_t res;
  res_t res_out;

  // Front end: classify and queue requests
  lnqd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .byte_value_i (byte_value_i),
    .cmd_hs_o     (cmd_hs),
    .cmd_take_i   (cmd_take),
    .cmd_o        (cmd)
  );

  // Back end: nibble store and pin sequencing
  lnqd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_vld_i  (cmd_hs.vld),
    .cmd_i      (cmd),
    .cmd_take_o (cmd_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res)
  );

  // Result queue
  lnqd_fifo #(
    .WIDTH ($bits(res_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign bus_nibble_o      = res_out.nibble;
  assign register_select_o = res_out.rs;
  assign enable_pin_o      = res_out.en;
  assign push_dropped_o    = res_out.dropped;
  assign queue_empty_o     = res_out.empty;

`ifndef SYNTH
  // A request leaves the command queue only with a result entering its queue
  a_take_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_hs.rdy |-> (cmd_hs.vld && res_push && !res_full))
    else $error("command taken without a result");

  // A refused push means the queue is nearly full, hence not empty
  a_drop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.dropped) |-> !res.empty)
    else $error("push refused with empty queue");

  // Only pushes can be refused
  a_drop_is_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.dropped) |-> (cmd.kind == KIND_DATA || cmd.kind == KIND_INSTR))
    else $error("non-push request flagged as dropped");
`endif

endmodule
